@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is held
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that also runs through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rled_pkg.sv @@
// ----------------------------------------------------------------------------
// rled_pkg
// shared constants, types and helper functions of the radial led engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rled_pkg;

    // wheel geometry
    localparam int SPOKE_COUNT    = 12;
    localparam int LEDS_PER_SPOKE = 8;
    localparam int STRIP_LENGTH   = 96;
    localparam int WHEEL_PIXELS   = SPOKE_COUNT * LEDS_PER_SPOKE;

    // request field widths
    localparam int CMD_W   = 3;
    localparam int COLOR_W = 24;
    localparam int SPOKE_W = 4;
    localparam int POS_W   = 3;
    localparam int PCT_W   = 16;
    localparam int SIDX_W  = 7;

    // packing of s_tdata, lowest field first
    localparam int COLOR_LSB = 0;
    localparam int SPOKE_LSB = COLOR_LSB + COLOR_W;
    localparam int POS_LSB   = SPOKE_LSB + SPOKE_W;
    localparam int PCT_LSB   = POS_LSB + POS_W;
    localparam int SIDX_LSB  = PCT_LSB + PCT_W;
    localparam int S_DATA_W  = SIDX_LSB + SIDX_W;
    localparam int S_TDATA_W = ((S_DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((COLOR_W + 7) / 8) * 8;

    // internal widths
    localparam int ADDR_W    = $clog2(STRIP_LENGTH);
    localparam int SEG_W     = $clog2(SPOKE_COUNT);
    localparam int LED_W     = (LEDS_PER_SPOKE > 1) ? $clog2(LEDS_PER_SPOKE) : 1;
    localparam int CNT_SPAN  = (SPOKE_COUNT > LEDS_PER_SPOKE) ? SPOKE_COUNT : LEDS_PER_SPOKE;
    localparam int CNT_W     = $clog2(CNT_SPAN);
    localparam int IDX_SPAN0 = (WHEEL_PIXELS > STRIP_LENGTH) ? WHEEL_PIXELS : STRIP_LENGTH;
    localparam int IDX_SPAN  = (IDX_SPAN0 > (2 ** SIDX_W)) ? IDX_SPAN0 : (2 ** SIDX_W);
    localparam int IDX_W     = $clog2(IDX_SPAN + 1);

    // percent to level arithmetic, q1.15 with round half up
    localparam int Q_FRAC     = 15;
    localparam int ROUND_HALF = 2 ** (Q_FRAC - 1);
    localparam int PROD_W     = PCT_W + 8;
    localparam int LVL_W      = PROD_W - Q_FRAC;

    // conditional subtracts needed to wrap a spoke number
    localparam int SPOKE_MOD_STEPS = ((2 ** SPOKE_W) - 1) / SPOKE_COUNT;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_ALL    = 3'd0,
        CMD_SET_LED    = 3'd1,
        CMD_FILL_LEVEL = 3'd2,
        CMD_FILL_PCT   = 3'd3,
        CMD_RING_ALL   = 3'd4,
        CMD_RING_PCT   = 3'd5,
        CMD_ROTATE     = 3'd6,
        CMD_READ       = 3'd7
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic             draw;
        logic             rot_rd;
        logic             rot_wr;
        logic             rot_swap;
        logic             clear_all;
        logic             rd_pixel;
        logic             load_out;
        logic [CNT_W-1:0] cnt;
        logic [SEG_W-1:0] seg;
        logic [LED_W-1:0] led;
    } dp_ctl_t;

    // datapath to controller
    typedef struct packed {
        cmd_t             cmd;
        logic [CNT_W-1:0] last;
    } dp_sts_t;

    // clamp(round(pct * n) - 1, 0, n - 1)
    function automatic logic [CNT_W-1:0] pct_level(input logic [PCT_W-1:0] pct, input int n);
        logic [PROD_W-1:0] prod;
        logic [LVL_W-1:0]  r;
        logic [LVL_W-1:0]  top;
        logic [LVL_W-1:0]  lvl;
        prod = PROD_W'(pct) * PROD_W'(n) + PROD_W'(ROUND_HALF);
        r    = prod[PROD_W-1:Q_FRAC];
        top  = LVL_W'(n - 1);
        if (r == '0) begin
            lvl = '0;
        end else if ((r - LVL_W'(1)) > top) begin
            lvl = top;
        end else begin
            lvl = r - LVL_W'(1);
        end
        return CNT_W'(lvl);
    endfunction

    // spoke number reduced into 0..SPOKE_COUNT-1
    function automatic logic [SEG_W-1:0] spoke_wrap(input logic [SPOKE_W-1:0] s);
        logic [SPOKE_W-1:0] v;
        v = s;
        for (int i = 0; i < SPOKE_MOD_STEPS; i++) begin
            if (32'(v) >= 32'(SPOKE_COUNT)) begin
                v = v - SPOKE_W'(SPOKE_COUNT);
            end
        end
        return SEG_W'(v);
    endfunction

    // strip index of led j on a logical spoke, serpentine wiring
    function automatic logic [IDX_W-1:0] led_addr(input logic [SEG_W-1:0] s,
                                                  input logic [IDX_W-1:0] led);
        logic [SEG_W:0]   t;
        logic [SEG_W:0]   seg;
        logic [IDX_W-1:0] base;
        t    = (SEG_W+1)'(SPOKE_COUNT + SPOKE_COUNT / 2) - {1'b0, s};
        seg  = (t >= (SEG_W+1)'(SPOKE_COUNT)) ? t - (SEG_W+1)'(SPOKE_COUNT) : t;
        base = IDX_W'(seg) * IDX_W'(LEDS_PER_SPOKE);
        return seg[0] ? base + led : base + IDX_W'(LEDS_PER_SPOKE - 1) - led;
    endfunction

endpackage

@@ rtl/radial_led_frame_drawing_engine_unit.sv @@
// ----------------------------------------------------------------------------
// radial_led_frame_drawing_engine_unit
// Each request runs to its result through the single read and single write port of
// the store; a rotate takes 13 x 8 store reads plus 12 segment swaps. One request
// at a time; the next one is taken once the result is registered.
// Synchronous reset makes the whole store read black at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module radial_led_frame_drawing_engine_unit
    import rled_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // color, spoke, position, percent, strip_index
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_color
    output logic [M_TDATA_W-1:0] m_tdata,
    // is_read
    output logic                 m_tuser
);

    logic               accept;
    dp_ctl_t            ctl;
    dp_sts_t            sts;
    logic [COLOR_W-1:0] read_color;

    assign accept = s_tvalid && s_tready;

    // sequencer
    rled_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .m_tready (m_tready),
        .sts      (sts),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .ctl      (ctl)
    );

    // store and arithmetic
    rled_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .in_command     (s_tuser),
        .in_color       (s_tdata[COLOR_LSB +: COLOR_W]),
        .in_spoke       (s_tdata[SPOKE_LSB +: SPOKE_W]),
        .in_position    (s_tdata[POS_LSB +: POS_W]),
        .in_percent     (s_tdata[PCT_LSB +: PCT_W]),
        .in_strip_index (s_tdata[SIDX_LSB +: SIDX_W]),
        .ctl            (ctl),
        .sts            (sts),
        .read_color     (read_color),
        .is_read        (m_tuser)
    );

    assign m_tdata = M_TDATA_W'(read_color);

    // checks
    `ASSERT_CLK(a_one_request_at_a_time, aclk, aresetn, accept |=> !s_tready, "request taken while busy")
    `ASSERT_CLK(a_no_result_overwrite, aclk, aresetn, ctl.load_out |-> (!m_tvalid || m_tready), "pending result overwritten")
    `ASSERT_CLK(a_non_read_is_black, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata == '0), "non read result carries colour")
    `ASSERT_ALWAYS(a_reset_drops_result, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

@@ rtl/rled_datapath.sv @@
// ----------------------------------------------------------------------------
// rled_datapath
// request registers, pixel store, rotate segment buffers and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rled_datapath
    import rled_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [CMD_W-1:0]   in_command,
    input  logic [COLOR_W-1:0] in_color,
    input  logic [SPOKE_W-1:0] in_spoke,
    input  logic [POS_W-1:0]   in_position,
    input  logic [PCT_W-1:0]   in_percent,
    input  logic [SIDX_W-1:0]  in_strip_index,
    input  dp_ctl_t            ctl,
    output dp_sts_t            sts,
    output logic [COLOR_W-1:0] read_color,
    output logic               is_read
);

    // request registers
    cmd_t               cmd_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [SEG_W-1:0]   spoke_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   last_reg;
    logic [SIDX_W-1:0]  sidx_reg;
    logic [CNT_W-1:0]   last_next;
    cmd_t               in_cmd;

    // pixel store
    logic [COLOR_W-1:0]      mem [STRIP_LENGTH];
    logic [STRIP_LENGTH-1:0] valid_reg;
    logic [COLOR_W-1:0]      bg_reg;
    logic [COLOR_W-1:0]      rdata_reg;
    logic                    rd_valid_reg;
    logic                    rd_in_reg;
    logic [COLOR_W-1:0]      pix_rdata;

    // rotate buffers
    logic [COLOR_W-1:0] hold_reg [LEDS_PER_SPOKE];
    logic [COLOR_W-1:0] cap_reg  [LEDS_PER_SPOKE];
    logic               rd_cap_reg;
    logic [LED_W-1:0]   rd_led_reg;

    // result register
    logic [COLOR_W-1:0] read_color_reg;
    logic               is_read_reg;

    // address and port logic
    logic               is_ring;
    logic               is_fill;
    logic [SEG_W-1:0]   draw_spoke;
    logic [IDX_W-1:0]   draw_led;
    logic [IDX_W-1:0]   draw_idx;
    logic               draw_ok;
    logic [IDX_W-1:0]   rot_idx;
    logic [IDX_W-1:0]   wr_idx;
    logic [COLOR_W-1:0] wr_data;
    logic               wr_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               rd_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    assign in_cmd = cmd_t'(in_command);

    // last loop count of the request
    always_comb begin
        case (in_cmd)
            CMD_FILL_LEVEL: begin
                if (IDX_W'(in_position) > IDX_W'(LEDS_PER_SPOKE - 1)) begin
                    last_next = CNT_W'(LEDS_PER_SPOKE - 1);
                end else begin
                    last_next = CNT_W'(in_position);
                end
            end
            CMD_FILL_PCT: last_next = pct_level(in_percent, LEDS_PER_SPOKE);
            CMD_RING_ALL: last_next = CNT_W'(SPOKE_COUNT - 1);
            CMD_RING_PCT: last_next = pct_level(in_percent, SPOKE_COUNT);
            default:      last_next = '0;
        endcase
    end

    // capture the request
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= in_cmd;
            color_reg <= in_color;
            spoke_reg <= spoke_wrap(in_spoke);
            pos_reg   <= in_position;
            last_reg  <= last_next;
            sidx_reg  <= in_strip_index;
        end
    end

    assign sts.cmd  = cmd_reg;
    assign sts.last = last_reg;

    // draw step: spoke and led from the loop count or the request
    assign is_ring    = (cmd_reg == CMD_RING_ALL) || (cmd_reg == CMD_RING_PCT);
    assign is_fill    = (cmd_reg == CMD_FILL_LEVEL) || (cmd_reg == CMD_FILL_PCT);
    assign draw_spoke = is_ring ? SEG_W'(ctl.cnt) : spoke_reg;
    assign draw_led   = is_fill ? IDX_W'(ctl.cnt) : IDX_W'(pos_reg);
    assign draw_idx   = led_addr(draw_spoke, draw_led);
    assign draw_ok    = draw_led < IDX_W'(LEDS_PER_SPOKE);

    // rotate step: same pixel is read and rewritten
    assign rot_idx = IDX_W'(ctl.seg) * IDX_W'(LEDS_PER_SPOKE) + IDX_W'(ctl.led);

    // store ports
    assign wr_idx  = ctl.rot_wr ? rot_idx : draw_idx;
    assign wr_data = ctl.rot_wr ? hold_reg[LED_W'(LEDS_PER_SPOKE - 1) - ctl.led] : color_reg;
    assign wr_en   = ((ctl.draw && draw_ok) || ctl.rot_wr) &&
                     (wr_idx < IDX_W'(STRIP_LENGTH));
    assign rd_idx  = ctl.rot_rd ? rot_idx : IDX_W'(sidx_reg);
    assign rd_en   = ctl.rot_rd || ctl.rd_pixel;
    assign wr_addr = wr_idx[ADDR_W-1:0];
    assign rd_addr = rd_idx[ADDR_W-1:0];

    // pixel memory, read before write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg    <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            rd_in_reg    <= rd_idx < IDX_W'(STRIP_LENGTH);
        end
    end

    // written flags and background colour, set all clears the flags and loads its colour as background
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            bg_reg    <= '0;
        end else if (ctl.clear_all) begin
            valid_reg <= '0;
            bg_reg    <= color_reg;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign pix_rdata = !rd_in_reg ? '0 : (rd_valid_reg ? rdata_reg : bg_reg);

    // rotate read tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_cap_reg <= 1'b0;
        end else begin
            rd_cap_reg <= ctl.rot_rd;
        end
    end

    always_ff @(posedge aclk) begin
        rd_led_reg <= ctl.led;
    end

    // collect the old segment, hand it over at the swap step
    always_ff @(posedge aclk) begin
        if (rd_cap_reg) begin
            cap_reg[rd_led_reg] <= pix_rdata;
        end
        if (ctl.rot_swap) begin
            for (int k = 0; k < LEDS_PER_SPOKE; k++) begin
                if (rd_cap_reg && (rd_led_reg == LED_W'(k))) begin
                    hold_reg[k] <= pix_rdata;
                end else begin
                    hold_reg[k] <= cap_reg[k];
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            read_color_reg <= (cmd_reg == CMD_READ) ? pix_rdata : '0;
            is_read_reg    <= cmd_reg == CMD_READ;
        end
    end

    assign read_color = read_color_reg;
    assign is_read    = is_read_reg;

endmodule

@@ rtl/rled_ctrl.sv @@
// ----------------------------------------------------------------------------
// rled_ctrl
// request sequencer: draw loops, rotate sweep and result handoff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rled_ctrl
    import rled_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    accept,
    input  logic    m_tready,
    input  dp_sts_t sts,
    output logic    s_tready,
    output logic    m_tvalid,
    output dp_ctl_t ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAW,
        ST_ROT_PRE,
        ST_ROT_SWAP,
        ST_ROT_STEP,
        ST_FINISH
    } state_t;

    localparam logic [LED_W-1:0] LAST_LED = LED_W'(LEDS_PER_SPOKE - 1);
    localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(SPOKE_COUNT - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [LED_W-1:0] led_reg, led_next;
    logic             out_valid_reg, out_valid_next;

    // next state and datapath commands
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        seg_next      = seg_reg;
        led_next      = led_reg;
        ctl           = '0;
        ctl.cnt       = cnt_reg;
        ctl.seg       = seg_reg;
        ctl.led       = led_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (sts.cmd)
                    CMD_SET_ALL: begin
                        ctl.clear_all = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    CMD_ROTATE: begin
                        seg_next   = LAST_SEG;
                        led_next   = '0;
                        state_next = ST_ROT_PRE;
                    end
                    CMD_READ: begin
                        ctl.rd_pixel = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    default: begin
                        cnt_next   = '0;
                        state_next = ST_DRAW;
                    end
                endcase
            end
            ST_DRAW: begin
                ctl.draw = 1'b1;
                if (cnt_reg == sts.last) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            // read the last segment before anything is rewritten
            ST_ROT_PRE: begin
                ctl.rot_rd = 1'b1;
                if (led_reg == LAST_LED) begin
                    led_next   = '0;
                    seg_next   = '0;
                    state_next = ST_ROT_SWAP;
                end else begin
                    led_next = led_reg + LED_W'(1);
                end
            end
            ST_ROT_SWAP: begin
                ctl.rot_swap = 1'b1;
                state_next   = ST_ROT_STEP;
            end
            ST_ROT_STEP: begin
                ctl.rot_rd = 1'b1;
                ctl.rot_wr = 1'b1;
                if (led_reg == LAST_LED) begin
                    led_next = '0;
                    if (seg_reg == LAST_SEG) begin
                        state_next = ST_FINISH;
                    end else begin
                        seg_next   = seg_reg + SEG_W'(1);
                        state_next = ST_ROT_SWAP;
                    end
                end else begin
                    led_next = led_reg + LED_W'(1);
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result slot
    always_comb begin
        if (ctl.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            seg_reg       <= '0;
            led_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seg_reg       <= seg_next;
            led_reg       <= led_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;

endmodule

@@ tb/sv/radial_led_frame_drawing_engine_unit_test.sv @@
// ----------------------------------------------------------------------------
// radial_led_frame_drawing_engine_unit_test
// Self-checking bench for the radial led frame drawing engine. A behavioral
// copy of the 96-pixel frame tracks every drawing request. The pixel reads
// the engine answers are compared with it, field by field. Directed requests
// cover the geometry corners, then a weighted random mix runs with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radial_led_frame_drawing_engine_unit_test;
    import rled_pkg::*;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic               is_read;
    } pixel_reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // color, spoke, position, percent, strip_index
    logic [S_TDATA_W-1:0] s_tdata;
    // command
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // read_color
    logic [M_TDATA_W-1:0] m_tdata;
    // is_read
    logic                 m_tuser;

    // behavioral frame and the replies it predicts
    logic [COLOR_W-1:0] frame_model [0:STRIP_LENGTH-1];
    pixel_reply_t       replies_due [$];

    int mismatch_count = 0;
    int requests_sent  = 0;
    int reads_checked  = 0;
    int rotations_sent = 0;
    int gap_pct        = 0;
    int stall_pct      = 0;
    int ready_hold     = 0;

    radial_led_frame_drawing_engine_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input int chance);
        if ($urandom_range(0, 99) >= chance) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(12, 48);
        return $urandom_range(1, 3);
    endfunction

    // strip position of an led on a logical spoke, -1 when off the spoke
    function automatic int led_index(input int spoke, input int led);
        int s;
        int seg;
        s = spoke % SPOKE_COUNT;
        if (led >= LEDS_PER_SPOKE) return -1;
        seg = (SPOKE_COUNT + SPOKE_COUNT / 2 - s) % SPOKE_COUNT;
        if (seg % 2 == 1) return seg * LEDS_PER_SPOKE + led;
        return (seg + 1) * LEDS_PER_SPOKE - 1 - led;
    endfunction

    // q1.15 fraction to a level, halves round up
    function automatic int percent_to_level(input int pct, input int n);
        int r;
        r = (pct * n + 16384) >>> 15;
        if (r == 0) return 0;
        return (r - 1 > n - 1) ? n - 1 : r - 1;
    endfunction

    function automatic void paint_led(input logic [COLOR_W-1:0] c, input int spoke,
                                      input int led);
        int idx;
        idx = led_index(spoke, led);
        if (idx >= 0 && idx < STRIP_LENGTH) frame_model[idx] = c;
    endfunction

    // updates the frame for one request and returns the reply it gives
    function automatic pixel_reply_t apply_to_frame(input cmd_t op,
                                                    input logic [COLOR_W-1:0] c,
                                                    input logic [SPOKE_W-1:0] spoke,
                                                    input logic [POS_W-1:0] pos,
                                                    input logic [PCT_W-1:0] pct,
                                                    input logic [SIDX_W-1:0] sidx);
        pixel_reply_t       reply;
        logic [COLOR_W-1:0] snap [0:WHEEL_PIXELS-1];
        int                 lvl;
        int                 src;
        int                 dst;
        reply.color   = '0;
        reply.is_read = 1'b0;
        case (op)
            CMD_SET_ALL: begin
                for (int i = 0; i < STRIP_LENGTH; i++) frame_model[i] = c;
            end
            CMD_SET_LED: begin
                paint_led(c, spoke, pos);
            end
            CMD_FILL_LEVEL, CMD_FILL_PCT: begin
                lvl = (op == CMD_FILL_LEVEL) ? int'(pos)
                                             : percent_to_level(pct, LEDS_PER_SPOKE);
                if (lvl > LEDS_PER_SPOKE - 1) lvl = LEDS_PER_SPOKE - 1;
                for (int i = 0; i <= lvl; i++) paint_led(c, spoke, i);
            end
            CMD_RING_ALL: begin
                for (int i = 0; i < SPOKE_COUNT; i++) paint_led(c, i, pos);
            end
            CMD_RING_PCT: begin
                lvl = percent_to_level(pct, SPOKE_COUNT);
                for (int i = 0; i <= lvl; i++) paint_led(c, i, pos);
            end
            CMD_ROTATE: begin
                for (int j = 0; j < WHEEL_PIXELS; j++)
                    snap[j] = (j < STRIP_LENGTH) ? frame_model[j] : '0;
                // each segment takes the previous one reversed, 0 takes the last
                for (int seg = 0; seg < SPOKE_COUNT; seg++) begin
                    src = (seg == 0) ? SPOKE_COUNT - 1 : seg - 1;
                    for (int j = 0; j < LEDS_PER_SPOKE; j++) begin
                        dst = seg * LEDS_PER_SPOKE + j;
                        if (dst < STRIP_LENGTH)
                            frame_model[dst] = snap[src * LEDS_PER_SPOKE
                                                    + LEDS_PER_SPOKE - 1 - j];
                    end
                end
            end
            default: begin
                reply.is_read = 1'b1;
                if (int'(sidx) < STRIP_LENGTH) reply.color = frame_model[sidx];
            end
        endcase
        return reply;
    endfunction

    // drive one request and record its predicted reply once accepted
    task automatic issue_request(input cmd_t op, input logic [COLOR_W-1:0] c,
                                 input logic [SPOKE_W-1:0] spoke,
                                 input logic [POS_W-1:0] pos,
                                 input logic [PCT_W-1:0] pct,
                                 input logic [SIDX_W-1:0] sidx);
        int gap;
        gap = pick_gap(gap_pct);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({sidx, pct, pos, spoke, c});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        replies_due.push_back(apply_to_frame(op, c, spoke, pos, pct, sidx));
        requests_sent++;
        if (op == CMD_ROTATE) rotations_sent++;
    endtask

    task automatic read_led(input int spoke, input int led);
        issue_request(CMD_READ, COLOR_W'($urandom()), '0, '0, '0,
                      SIDX_W'(led_index(spoke, led)));
    endtask

    // result side stalls
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else begin
            ready_hold <= pick_gap(stall_pct);
            m_tready   <= (ready_hold == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // reply check against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $error("reply with nothing outstanding: read_color %06h is_read %0b",
                       m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                if (m_tdata !== M_TDATA_W'(replies_due[0].color)) begin
                    $error("read_color mismatch: expected %06h, got %06h",
                           replies_due[0].color, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== replies_due[0].is_read) begin
                    $error("is_read mismatch: expected %0b, got %0b",
                           replies_due[0].is_read, m_tuser);
                    mismatch_count++;
                end
                if (replies_due[0].is_read) reads_checked++;
                void'(replies_due.pop_front());
            end
        end
    end

    // whole-strip fill, reads at both ends and past the store
    task automatic test_set_all();
        issue_request(CMD_SET_ALL, 24'hFFFFFF, '0, '0, '0, '0);
        issue_request(CMD_READ, '0, '0, '0, '0, 7'd0);
        issue_request(CMD_READ, '0, '0, '0, '0, 7'(STRIP_LENGTH - 1));
        issue_request(CMD_READ, '0, '0, '0, '0, 7'd127);
    endtask

    // single leds at spoke and led extremes, spoke number wrapping
    task automatic test_single_led();
        issue_request(CMD_SET_LED, 24'h000000, 4'd0, 3'd0, '0, '0);
        issue_request(CMD_SET_LED, 24'h123456, 4'd11, 3'd7, '0, '0);
        issue_request(CMD_SET_LED, 24'hA5C3E1, 4'd15, 3'd3, '0, '0);
        read_led(0, 0);
        read_led(11, 7);
        read_led(3, 3);
    endtask

    // fill to a level, full and minimal, with spoke wrap
    task automatic test_fill_level();
        issue_request(CMD_FILL_LEVEL, 24'h00FF00, 4'd5, 3'd7, '0, '0);
        issue_request(CMD_FILL_LEVEL, 24'h0000FF, 4'd12, 3'd0, '0, '0);
        read_led(5, 7);
    endtask

    // percent fills: zero, saturated, and the rounding boundaries
    task automatic test_fill_percent();
        issue_request(CMD_FILL_PCT, 24'h111111, 4'd1, '0, 16'd0, '0);
        issue_request(CMD_FILL_PCT, 24'h222222, 4'd2, '0, 16'hFFFF, '0);
        issue_request(CMD_FILL_PCT, 24'h333333, 4'd4, '0, 16'd2047, '0);
        issue_request(CMD_FILL_PCT, 24'h444444, 4'd6, '0, 16'd6144, '0);
        read_led(6, 1);
    endtask

    // rings on every spoke and on a percent-selected set of spokes
    task automatic test_rings();
        issue_request(CMD_RING_ALL, 24'hFF0000, '0, 3'd7, '0, '0);
        issue_request(CMD_RING_ALL, 24'h00FFFF, '0, 3'd0, '0, '0);
        issue_request(CMD_RING_PCT, 24'hFF00FF, '0, 3'd4, 16'hFFFF, '0);
        issue_request(CMD_RING_PCT, 24'hFFFF00, '0, 3'd2, 16'd0, '0);
    endtask

    // two clockwise steps on a patterned frame
    task automatic test_rotate();
        issue_request(CMD_ROTATE, '0, '0, '0, '0, '0);
        issue_request(CMD_ROTATE, '0, '0, '0, '0, '0);
        read_led(0, 0);
        read_led(7, 4);
    endtask

    // percent near a rounding step now and then, else uniform
    function automatic logic [PCT_W-1:0] pick_percent(input int n);
        int r;
        int p;
        if ($urandom_range(0, 3) != 0) return PCT_W'($urandom());
        r = $urandom_range(1, n + 1);
        p = ((2 * r - 1) * 16384) / n + $urandom_range(0, 2) - 1;
        if (p < 0) p = 0;
        if (p > 65535) p = 65535;
        return PCT_W'(p);
    endfunction

    // weighted random mix in blocks, some blocks with no idling at all
    task automatic test_random_mix(input int count);
        int   pick;
        cmd_t op;
        logic [SIDX_W-1:0] sidx;
        logic [PCT_W-1:0]  pct;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                gap_pct   = ((n / 50) % 3 == 0) ? 0 : 30;
                stall_pct = ((n / 50) % 3 == 0) ? 0 : 35;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)      op = CMD_READ;
            else if (pick < 55) op = CMD_SET_LED;
            else if (pick < 65) op = CMD_FILL_LEVEL;
            else if (pick < 75) op = CMD_FILL_PCT;
            else if (pick < 83) op = CMD_RING_ALL;
            else if (pick < 91) op = CMD_RING_PCT;
            else if (pick < 97) op = CMD_ROTATE;
            else                op = CMD_SET_ALL;
            sidx = ($urandom_range(0, 99) < 85) ? SIDX_W'($urandom_range(0, STRIP_LENGTH - 1))
                                                : SIDX_W'($urandom_range(0, 127));
            pct  = pick_percent((op == CMD_RING_PCT) ? SPOKE_COUNT : LEDS_PER_SPOKE);
            issue_request(op, COLOR_W'($urandom()), SPOKE_W'($urandom()), POS_W'($urandom()),
                          pct, sidx);
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_SET_ALL;
        m_tready = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        test_set_all();
        test_single_led();
        test_fill_level();
        test_fill_percent();
        test_rings();
        test_rotate();
        test_random_mix(450);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (130) @(posedge aclk);

        $display("covered %0d requests including %0d rotations; %0d pixel reads compared",
                 requests_sent, rotations_sent, reads_checked);
        if (mismatch_count == 0) begin
            $display("radial_led_frame_drawing_engine_unit_test: PASS");
        end else begin
            $display("radial_led_frame_drawing_engine_unit_test: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("radial_led_frame_drawing_engine_unit_test: FAIL");
        $finish;
    end

endmodule
